[src/aabb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package aabb_pkg;

    localparam int SLOTS = 8;
    localparam int KINDS = 10;
    localparam int SLOT_W = 3;
    localparam logic [3:0] KIND_NONE = 4'd0;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_MARK   = 3'd1;
    localparam logic [2:0] OP_ACTIVE = 3'd2;
    localparam logic [2:0] OP_PURGE  = 3'd3;
    localparam logic [2:0] OP_SCAN   = 3'd4;
    localparam logic [2:0] OP_QUERY  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [0:0] REG_MASK_LOW  = 1'd0;
    localparam logic [0:0] REG_MASK_HIGH = 1'd1;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [2:0]         slot;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
        logic [3:0]         kind;
        logic               has_listener;
        logic               active_flag;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot_a;
        logic [2:0] slot_b;
        logic       pair_valid;
        logic       notify_a;
        logic       notify_b;
        logic       hit;
        logic       last;
    } t_rsp;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_box;

    function automatic logic boxes_overlap(input t_box a, input t_box b);
        logic signed [17:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
        ax0 = 18'(a.x);
        ax1 = 18'(a.x) + 18'(signed'({1'b0, a.w}));
        bx0 = 18'(b.x);
        bx1 = 18'(b.x) + 18'(signed'({1'b0, b.w}));
        ay0 = 18'(a.y);
        ay1 = 18'(a.y) + 18'(signed'({1'b0, a.h}));
        by0 = 18'(b.y);
        by1 = 18'(b.y) + 18'(signed'({1'b0, b.h}));
        return (ax0 <= bx1) && (ax1 >= bx0) && (ay0 <= by1) && (ay1 >= by0);
    endfunction

    function automatic logic mask_allowed(input logic [59:0] lo, input logic [39:0] hi,
                                          input logic [3:0] row, input logic [3:0] col);
        logic [6:0] bitn;
        logic       res;
        bitn = '0;
        res  = 1'b0;
        if (row >= 4'd1 && row <= 4'(KINDS) && col >= 4'd1 && col <= 4'(KINDS)) begin
            if (row <= 4'd6) begin
                bitn = 7'(({3'd0, row} - 7'd1) * 7'd10 + ({3'd0, col} - 7'd1));
                res  = lo[bitn[5:0]];
            end else begin
                bitn = 7'(({3'd0, row} - 7'd7) * 7'd10 + ({3'd0, col} - 7'd1));
                res  = hi[bitn[5:0]];
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[src/aabb_pair_collision_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// eight-slot rectangle table with one shared overlap/mask unit stepped by a small sequencer.
// a request is accepted when start is high and busy is low. add, mark, set active, purge and
// the unused opcodes finish in the exec state; query then visits slots in order up to the
// first hit or the last slot; scan has a setup step, walks the 28 pairs i<j and ends with a
// done item. busy drops in the cycle in which a request's last result sits on o_rsp, so the
// next request can be accepted at the edge that takes it. results appear on o_rsp for exactly
// one cycle marked by o_rsp_valid; the receiver cannot stall them. the pair masks sit at byte
// addresses 0 and 8; the user must change them only while busy is low (not enforced by the block).
module aabb_pair_collision_table (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire aabb_pkg::t_req i_req,
    output logic               o_rsp_valid,
    output aabb_pkg::t_rsp     o_rsp,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import aabb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_QUERY = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [59:0]       r_mask_lo;
    logic [39:0]       r_mask_hi;
    t_req              r_req;
    t_box              r_rect [SLOTS];
    logic [3:0]        r_kind [SLOTS];
    logic [SLOTS-1:0]  r_used, r_marked, r_active, r_listens;
    logic [SLOT_W-1:0] r_i, r_j;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    logic              wr_en;
    logic              live_i, live_j, ov, na, nb, q_ok;
    logic [SLOT_W-1:0] free_idx;
    logic              has_free;
    t_box              q_box;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign busy   = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp  = r_out;

    always_comb begin
        prdata = '0;
        unique case (paddr[3])
            REG_MASK_LOW:  prdata = {4'd0, r_mask_lo};
            REG_MASK_HIGH: prdata = {24'd0, r_mask_hi};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        free_idx = '0;
        has_free = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_idx = SLOT_W'(k);
                has_free = 1'b1;
            end
        end
    end

    assign q_box  = '{x: r_req.rect_x, y: r_req.rect_y, w: r_req.rect_w, h: r_req.rect_h};
    assign live_i = r_used[r_i] && r_active[r_i] && !r_marked[r_i] && r_kind[r_i] != KIND_NONE;
    assign live_j = r_used[r_j] && r_active[r_j] && !r_marked[r_j] && r_kind[r_j] != KIND_NONE;
    // shared unit: slot i against slot j in scan, slot i against request in query
    assign ov = boxes_overlap(r_rect[r_i], (r_state == S_SCAN) ? r_rect[r_j] : q_box);
    assign na = mask_allowed(r_mask_lo, r_mask_hi, r_kind[r_i],
                             (r_state == S_SCAN) ? r_kind[r_j] : r_req.kind);
    assign nb = mask_allowed(r_mask_lo, r_mask_hi,
                             (r_state == S_SCAN) ? r_kind[r_j] : r_req.kind, r_kind[r_i]);
    assign q_ok = r_used[r_i] && !r_marked[r_i] && (na || nb) && ov;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_req.opcode == OP_SCAN) n_state = S_SCAN;
                else if (r_req.opcode == OP_QUERY) n_state = S_QUERY;
                else n_state = S_IDLE;
            end
            S_SCAN: begin
                if (r_i == SLOT_W'(SLOTS - 2) && r_j == SLOT_W'(SLOTS - 1)) n_state = S_DONE;
            end
            S_QUERY: begin
                if (q_ok || r_i == SLOT_W'(SLOTS - 1)) n_state = S_IDLE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = 1'b0;
        n_out       = '0;
        unique case (r_state)
            S_IDLE: ;
            S_EXEC: begin
                n_out_valid = (r_req.opcode != OP_SCAN) && (r_req.opcode != OP_QUERY);
                n_out.last  = 1'b1;
                case (r_req.opcode) inside
                    OP_ADD: begin
                        if (has_free) begin
                            n_out.slot_a = free_idx;
                        end else begin
                            n_out.status = ST_FULL;
                        end
                    end
                    OP_MARK, OP_ACTIVE: begin
                        if (!r_used[r_req.slot]) begin
                            n_out.status = ST_EMPTY;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (live_i && live_j && ov &&
                    ((na && r_listens[r_i]) || (nb && r_listens[r_j]))) begin
                    n_out_valid      = 1'b1;
                    n_out.slot_a     = r_i;
                    n_out.slot_b     = r_j;
                    n_out.pair_valid = 1'b1;
                    n_out.notify_a   = na && r_listens[r_i];
                    n_out.notify_b   = nb && r_listens[r_j];
                end
            end
            S_QUERY: begin
                if (q_ok || r_i == SLOT_W'(SLOTS - 1)) begin
                    n_out_valid = 1'b1;
                    n_out.hit   = q_ok;
                    n_out.last  = 1'b1;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out.last  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
            r_i   <= '0;
            r_j   <= SLOT_W'(1);
        end
        if (r_state == S_EXEC && r_req.opcode == OP_ADD && has_free) begin
            r_rect[free_idx]    <= q_box;
            r_kind[free_idx]    <= r_req.kind;
            r_listens[free_idx] <= r_req.has_listener;
            r_active[free_idx]  <= 1'b1;
        end
        if (r_state == S_EXEC && r_req.opcode == OP_ACTIVE && r_used[r_req.slot]) begin
            r_active[r_req.slot] <= r_req.active_flag;
        end
        if (r_state == S_SCAN) begin
            if (r_j == SLOT_W'(SLOTS - 1)) begin
                r_i <= r_i + SLOT_W'(1);
                r_j <= r_i + SLOT_W'(2);
            end else begin
                r_j <= r_j + SLOT_W'(1);
            end
        end
        if (r_state == S_QUERY) begin
            r_i <= r_i + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_marked    <= '0;
            r_mask_lo   <= '0;
            r_mask_hi   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                unique case (paddr[3])
                    REG_MASK_LOW:  r_mask_lo <= pwdata[59:0];
                    REG_MASK_HIGH: r_mask_hi <= pwdata[39:0];
                    default: ;
                endcase
            end
            if (r_state == S_EXEC) begin
                case (r_req.opcode)
                    OP_ADD: begin
                        if (has_free) begin
                            r_used[free_idx]   <= 1'b1;
                            r_marked[free_idx] <= 1'b0;
                        end
                    end
                    OP_MARK: begin
                        if (r_used[r_req.slot]) r_marked[r_req.slot] <= 1'b1;
                    end
                    OP_PURGE: begin
                        r_used   <= r_used & ~r_marked;
                        r_marked <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire
